// File: rtl/iqms_pkg.sv
// ----------------------------------------------------------------------------
// iqms_pkg
// Widths and constants shared by the I/Q magnitude statistics block.
// ----------------------------------------------------------------------------
package iqms_pkg;

  localparam int SAMPLE_W = 8;   // offset-binary I or Q byte
  localparam int MAG_W    = 9;   // Q8 magnitude, 0..362
  localparam int PROD_W   = 18;  // 9x9 product
  localparam int ENERGY_W = 16;  // I'^2 + Q'^2, at most 32768
  localparam int RAD_W    = 18;  // square-root radicand, two bits per step
  localparam int SQ_W     = 17;  // square of a magnitude, at most 131044
  localparam int STEP_W   = 5;   // iteration counter
  localparam int OUT_CNT_W = 32; // reported sample count

  localparam logic [MAG_W-1:0]  MAG_ONE    = 9'd256;
  localparam logic [STEP_W-1:0] ROOT_LAST  = 5'd8;   // 9 root bits
  localparam logic [STEP_W-1:0] MEAN_LAST  = 5'd8;   // 9 quotient bits
  localparam logic [STEP_W-1:0] MSQ_LAST   = 5'd16;  // 17 quotient bits

endpackage

// File: rtl/iqms_if.sv
// ----------------------------------------------------------------------------
// iqms_if
// Valid/ready channels for I/Q samples in and record statistics out.
// ----------------------------------------------------------------------------
interface iqms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] i_sample;
  logic [7:0] q_sample;
  logic       last_sample;

  modport source (output valid, i_sample, q_sample, last_sample, input ready);
  modport sink   (input valid, i_sample, q_sample, last_sample, output ready);
endinterface

interface iqms_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  mean_mag;
  logic [8:0]  std_dev;
  logic [8:0]  max_mag;
  logic [8:0]  min_mag;
  logic [31:0] sample_count;

  modport source (output valid, mean_mag, std_dev, max_mag, min_mag, sample_count,
                  input ready);
  modport sink   (input valid, mean_mag, std_dev, max_mag, min_mag, sample_count,
                  output ready);
endinterface

// File: rtl/iqms_mul.sv
// ----------------------------------------------------------------------------
// iqms_mul
// Shared 9x9 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module iqms_mul (
  input  logic                         clk,
  input  logic [iqms_pkg::MAG_W-1:0]   a,
  input  logic [iqms_pkg::MAG_W-1:0]   b,
  output logic [iqms_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: rtl/iqms_cmpsub.sv
// ----------------------------------------------------------------------------
// iqms_cmpsub
// Shared compare-and-subtract step for the square roots, the divisions and the variance.
// ----------------------------------------------------------------------------
module iqms_cmpsub #(
  parameter int W = 49
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  assign ge   = (a >= b);
  assign diff = a - b;

endmodule

// File: rtl/iq_magnitude_statistics_core.sv
// ----------------------------------------------------------------------------
// iq_magnitude_statistics_core
// Per-record magnitude mean, deviation, min, max and count of I/Q samples.
// ----------------------------------------------------------------------------
// Each offset-binary I/Q pair is centred, its Q8 magnitude floor(sqrt(4*(I^2+Q^2)))
// is found bit by bit, and the record's min (starting at 1.0), max, sum, sum of
// squares and saturating count are updated. A beat with last_sample set also
// closes the record: one result beat carries mean, standard deviation, max, min
// and count, and the statistics clear. A sample is taken only in the idle state,
// so ready is low while a sample is processed; a last sample holds the input off
// through the report and any wait for the output register to drain. The work is
// done by one shared compare-subtract unit (9 root steps per sample, then 9 + 17
// division steps and 9 root steps per report) and one shared 9x9 multiplier.
module iq_magnitude_statistics_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  iqms_in_if.sink           sample_in,
  iqms_out_if.source        stats_out
);

  localparam int MSUM_W = COUNT_BITS + iqms_pkg::MAG_W;
  localparam int SSUM_W = COUNT_BITS + iqms_pkg::SQ_W;
  localparam int EXT_W  = (COUNT_BITS > iqms_pkg::OUT_CNT_W) ? COUNT_BITS
                                                             : iqms_pkg::OUT_CNT_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQI    = 4'd1;
  localparam logic [3:0] S_SQQ    = 4'd2;
  localparam logic [3:0] S_SUMQ   = 4'd3;
  localparam logic [3:0] S_ROOT   = 4'd4;
  localparam logic [3:0] S_MAGSQ  = 4'd5;
  localparam logic [3:0] S_ACCUM  = 4'd6;
  localparam logic [3:0] S_DIVM   = 4'd7;
  localparam logic [3:0] S_DIVS   = 4'd8;
  localparam logic [3:0] S_MEANSQ = 4'd9;
  localparam logic [3:0] S_VAR    = 4'd10;
  localparam logic [3:0] S_REPORT = 4'd11;

  logic [3:0]                       state;
  logic [iqms_pkg::STEP_W-1:0]      cnt;
  logic                             rpt;
  logic                             last_q;
  logic [iqms_pkg::SAMPLE_W-1:0]    ai;
  logic [iqms_pkg::SAMPLE_W-1:0]    aq;
  logic [iqms_pkg::ENERGY_W-1:0]    energy;
  logic [iqms_pkg::RAD_W-1:0]       rad;
  logic [iqms_pkg::MAG_W-1:0]       root;
  logic [SSUM_W-1:0]                rem;
  logic [SSUM_W-1:0]                dvs;
  logic [iqms_pkg::SQ_W-1:0]        quo;
  logic [iqms_pkg::MAG_W-1:0]       mag;
  logic [iqms_pkg::MAG_W-1:0]       mean;
  logic [iqms_pkg::MAG_W-1:0]       std;

  logic [MSUM_W-1:0]                msum;
  logic [SSUM_W-1:0]                ssum;
  logic [iqms_pkg::MAG_W-1:0]       least;
  logic [iqms_pkg::MAG_W-1:0]       greatest;
  logic [COUNT_BITS-1:0]            seen;

  logic [MSUM_W-1:0]                msum_next;
  logic [SSUM_W-1:0]                ssum_next;
  logic [COUNT_BITS-1:0]            seen_next;
  logic                             seen_full;

  logic [iqms_pkg::MAG_W-1:0]       mul_a;
  logic [iqms_pkg::PROD_W-1:0]      prod;
  logic [SSUM_W-1:0]                cs_a;
  logic [SSUM_W-1:0]                cs_b;
  logic [SSUM_W-1:0]                cs_diff;
  logic                             cs_ge;
  logic [iqms_pkg::MAG_W-1:0]       root_next;
  logic [iqms_pkg::SQ_W-1:0]        var_val;
  logic [EXT_W-1:0]                 seen_ext;
  logic [iqms_pkg::OUT_CNT_W-1:0]   count_rpt;

  logic [iqms_pkg::SAMPLE_W-1:0]    abs_i;
  logic [iqms_pkg::SAMPLE_W-1:0]    abs_q;
  logic                             in_fire;
  logic                             out_free;

  assign sample_in.ready = (state == S_IDLE);
  assign in_fire  = sample_in.valid && sample_in.ready;
  assign out_free = !stats_out.valid || stats_out.ready;

  // |x - 128| fits in 8 bits, 128 included
  assign abs_i = sample_in.i_sample[7] ? {1'b0, sample_in.i_sample[6:0]}
                                       : 8'(8'd128 - sample_in.i_sample);
  assign abs_q = sample_in.q_sample[7] ? {1'b0, sample_in.q_sample[6:0]}
                                       : 8'(8'd128 - sample_in.q_sample);

  // multiplier operand: squares of I, Q, magnitude and mean
  always_comb begin
    unique case (state)
      S_SQI:    mul_a = {1'b0, ai};
      S_SQQ:    mul_a = {1'b0, aq};
      S_MAGSQ:  mul_a = mag;
      default:  mul_a = mean;
    endcase
  end

  iqms_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_a),
    .prod (prod)
  );

  // compare-subtract operands: root trial, division trial, or variance
  always_comb begin
    unique case (state)
      S_ROOT: begin
        cs_a = {rem[SSUM_W-3:0], rad[iqms_pkg::RAD_W-1 -: 2]};
        cs_b = SSUM_W'({root, 2'b01});
      end
      S_VAR: begin
        cs_a = SSUM_W'(quo);
        cs_b = SSUM_W'(prod);
      end
      default: begin
        cs_a = rem;
        cs_b = dvs;
      end
    endcase
  end

  iqms_cmpsub #(.W(SSUM_W)) u_cmpsub (
    .a    (cs_a),
    .b    (cs_b),
    .diff (cs_diff),
    .ge   (cs_ge)
  );

  assign root_next = {root[iqms_pkg::MAG_W-2:0], cs_ge};
  assign var_val   = cs_ge ? cs_diff[iqms_pkg::SQ_W-1:0] : '0;

  assign seen_full = (seen == {COUNT_BITS{1'b1}});
  assign msum_next = seen_full ? msum : msum + MSUM_W'(mag);
  assign ssum_next = seen_full ? ssum : ssum + SSUM_W'(prod);
  assign seen_next = seen_full ? seen : seen + 1'b1;

  assign seen_ext  = EXT_W'(seen);
  assign count_rpt = (seen_ext > EXT_W'({iqms_pkg::OUT_CNT_W{1'b1}}))
                   ? {iqms_pkg::OUT_CNT_W{1'b1}} : seen_ext[iqms_pkg::OUT_CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      rpt             <= 1'b0;
      stats_out.valid <= 1'b0;
      msum            <= '0;
      ssum            <= '0;
      least           <= iqms_pkg::MAG_ONE;
      greatest        <= '0;
      seen            <= '0;
    end else begin
      if ((state == S_REPORT) && out_free) begin
        stats_out.valid <= 1'b1;
      end else if (stats_out.valid && stats_out.ready) begin
        stats_out.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            ai     <= abs_i;
            aq     <= abs_q;
            last_q <= sample_in.last_sample;
            state  <= S_SQI;
          end
        end
        S_SQI: begin
          state <= S_SQQ;
        end
        S_SQQ: begin
          energy <= prod[iqms_pkg::ENERGY_W-1:0];
          state  <= S_SUMQ;
        end
        S_SUMQ: begin
          rad   <= {iqms_pkg::ENERGY_W'(energy + prod[iqms_pkg::ENERGY_W-1:0]), 2'b00};
          rem   <= '0;
          root  <= '0;
          cnt   <= iqms_pkg::ROOT_LAST;
          state <= S_ROOT;
        end
        S_ROOT: begin
          rem  <= cs_ge ? cs_diff : cs_a;
          root <= root_next;
          rad  <= {rad[iqms_pkg::RAD_W-3:0], 2'b00};
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            if (rpt) begin
              std   <= root_next;
              state <= S_REPORT;
            end else begin
              mag   <= root_next;
              state <= S_MAGSQ;
            end
          end
        end
        S_MAGSQ: begin
          state <= S_ACCUM;
        end
        S_ACCUM: begin
          if (mag < least) begin
            least <= mag;
          end
          if (mag > greatest) begin
            greatest <= mag;
          end
          msum <= msum_next;
          ssum <= ssum_next;
          seen <= seen_next;
          if (last_q) begin
            rem   <= SSUM_W'(msum_next);
            dvs   <= SSUM_W'({seen_next, 8'b0});
            quo   <= '0;
            cnt   <= iqms_pkg::MEAN_LAST;
            state <= S_DIVM;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIVM: begin
          if (cnt == '0) begin
            mean  <= {quo[iqms_pkg::MAG_W-2:0], cs_ge};
            rem   <= ssum;
            dvs   <= SSUM_W'({seen, 16'b0});
            quo   <= '0;
            cnt   <= iqms_pkg::MSQ_LAST;
            state <= S_DIVS;
          end else begin
            rem <= cs_ge ? cs_diff : rem;
            dvs <= dvs >> 1;
            quo <= {quo[iqms_pkg::SQ_W-2:0], cs_ge};
            cnt <= cnt - 1'b1;
          end
        end
        S_DIVS: begin
          rem <= cs_ge ? cs_diff : rem;
          dvs <= dvs >> 1;
          quo <= {quo[iqms_pkg::SQ_W-2:0], cs_ge};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_MEANSQ;
          end
        end
        S_MEANSQ: begin
          state <= S_VAR;
        end
        S_VAR: begin
          // clamp a negative variance at zero
          rad   <= iqms_pkg::RAD_W'(var_val);
          rem   <= '0;
          root  <= '0;
          rpt   <= 1'b1;
          cnt   <= iqms_pkg::ROOT_LAST;
          state <= S_ROOT;
        end
        S_REPORT: begin
          // hold until the output register is free
          if (out_free) begin
            stats_out.mean_mag     <= mean;
            stats_out.std_dev      <= std;
            stats_out.max_mag      <= greatest;
            stats_out.min_mag      <= least;
            stats_out.sample_count <= count_rpt;
            msum     <= '0;
            ssum     <= '0;
            least    <= iqms_pkg::MAG_ONE;
            greatest <= '0;
            seen     <= '0;
            rpt      <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
